// ===== rtl/cabs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cabs_pkg;

  localparam int unsigned CW = 14;
  localparam int unsigned SW = 16;
  localparam int unsigned LW = 7;
  localparam int unsigned AW = 29;
  localparam int unsigned MAX_BOXES_DEF = 64;
  localparam logic [SW-1:0] LIMIT_RST = 16'd29491;
  localparam logic [2:0] ADDR_LIMIT = 3'd0;

  typedef struct packed {
    logic [CW-1:0]        left;
    logic [CW-1:0]        top;
    logic [CW-1:0]        right;
    logic [CW-1:0]        bottom;
    logic [SW-1:0]        score;
    logic [LW-1:0]        cls;
    logic signed [AW-1:0] area;
    logic                 sup;
  } box_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic push_here;
    logic in_range;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_POP,
    ST_ROT,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/cabs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cabs_box_if;
  logic        valid;
  logic        ready;
  logic [13:0] box_left;
  logic [13:0] box_top;
  logic [13:0] box_right;
  logic [13:0] box_bottom;
  logic [15:0] score;
  logic [6:0]  class_label;
  logic        last_item;
  modport source (output valid, box_left, box_top, box_right, box_bottom, score,
                  class_label, last_item, input ready);
  modport sink (input valid, box_left, box_top, box_right, box_bottom, score,
                class_label, last_item, output ready);
endinterface

interface cabs_kept_if;
  logic        valid;
  logic        ready;
  logic [13:0] kept_left;
  logic [13:0] kept_top;
  logic [13:0] kept_right;
  logic [13:0] kept_bottom;
  logic [15:0] kept_score;
  logic [6:0]  kept_class;
  logic        final_result;
  logic        overflowed;
  modport source (output valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                  kept_class, final_result, overflowed, input ready);
  modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                kept_class, final_result, overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/cabs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cabs_cell (
  input  wire                clk_i,
  input  cabs_pkg::cell_ctrl_t ctrl_i,
  input  wire                prev_keep_i,
  input  cabs_pkg::box_t     prev_box_i,
  input  cabs_pkg::box_t     next_box_i,
  input  cabs_pkg::box_t     new_box_i,
  input  cabs_pkg::box_t     push_box_i,
  output logic               keep_o,
  output cabs_pkg::box_t     box_o
);

  cabs_pkg::box_t box_q;
  cabs_pkg::box_t box_d;

  assign keep_o = ctrl_i.in_range && (box_q.score >= new_box_i.score);
  assign box_o  = box_q;

  always_comb begin
    box_d = box_q;
    if (ctrl_i.load) begin
      if (!keep_o) begin
        box_d = prev_keep_i ? new_box_i : prev_box_i;
      end
    end else if (ctrl_i.pop) begin
      box_d = ctrl_i.push_here ? push_box_i : next_box_i;
    end else if (ctrl_i.push_here) begin
      box_d = push_box_i;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

endmodule
`default_nettype wire

// ===== rtl/cabs_ovl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cabs_ovl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire [15:0]          limit_i,
  input  cabs_pkg::box_t      ref_i,
  input  cabs_pkg::box_t      x_i,
  input  wire                 x_valid_i,
  output logic                push_valid_o,
  output cabs_pkg::box_t      push_box_o
);

  logic [13:0]        lmax, tmax, rmin, bmin, iw, ih;
  logic signed [14:0] iw_s, ih_s;
  logic [27:0]        inter_d, inter_q;
  logic               cand_d, cand_q, v_q;
  cabs_pkg::box_t     x_q;
  logic signed [30:0] uni;
  logic signed [47:0] prod, lhs;
  logic               mark;

  always_comb begin
    lmax = (ref_i.left > x_i.left) ? ref_i.left : x_i.left;
    tmax = (ref_i.top > x_i.top) ? ref_i.top : x_i.top;
    rmin = (ref_i.right < x_i.right) ? ref_i.right : x_i.right;
    bmin = (ref_i.bottom < x_i.bottom) ? ref_i.bottom : x_i.bottom;
    iw_s = $signed({1'b0, rmin}) - $signed({1'b0, lmax});
    ih_s = $signed({1'b0, bmin}) - $signed({1'b0, tmax});
    iw = iw_s[14] ? 14'd0 : iw_s[13:0];
    ih = ih_s[14] ? 14'd0 : ih_s[13:0];
    inter_d = iw * ih;
    cand_d = !x_i.sup && (x_i.cls == ref_i.cls);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= x_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_i;
    inter_q <= inter_d;
    cand_q  <= cand_d;
  end

  always_comb begin
    uni  = $signed({{2{ref_i.area[28]}}, ref_i.area}) + $signed({{2{x_q.area[28]}}, x_q.area})
           - $signed({3'b000, inter_q});
    prod = $signed({1'b0, limit_i}) * uni;
    lhs  = $signed({4'b0000, inter_q, 16'h0000});
    mark = cand_q && !uni[30] && (lhs > prod);
    push_box_o     = x_q;
    push_box_o.sup = x_q.sup | mark;
  end

  assign push_valid_o = v_q;

endmodule
`default_nettype wire

// ===== rtl/class_aware_box_suppression.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Kind                Transfer
// box_i     in         cabs_box_if.sink    valid & ready at a rising edge
// kept_o    out        cabs_kept_if.source valid & ready at a rising edge
// apb       in         APB-style, 32 bits  psel & penable & pwrite & pready
//
// Boxes load one per cycle in the load state only; each is inserted in score
// order in a row of cells. After the last box each kept box rotates the
// remaining boxes through the two-stage overlap unit; a suppressed box is
// dropped when it reaches the head.
// Reset clears the control state and sets the threshold to its default.
// A kept box waits in a pending register and then in the output register;
// selection stalls while both are full and unread, and no box is taken meanwhile.
module class_aware_box_suppression #(
  parameter int unsigned MAX_BOXES = cabs_pkg::MAX_BOXES_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  cabs_box_if.sink     box_i,
  cabs_kept_if.source  kept_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [2:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned KW = $clog2(MAX_BOXES + 1);

  cabs_pkg::state_e state_q, state_d;
  logic [KW-1:0]    k_q, k_d, rem_q, rem_d;
  logic             ovf_q, ovf_d;
  logic [15:0]      limit_q;
  logic             pend_v_q, pend_v_d;
  cabs_pkg::box_t   pend_q, ref_q;
  logic             out_v_q;
  cabs_pkg::box_t   out_q;
  logic             out_fin_q, out_ovf_q;

  logic             box_acc, ld, pop, grab, out_ld, out_fin, out_free;
  logic             push_v;
  cabs_pkg::box_t   push_box, new_box, head;
  cabs_pkg::box_t   boxes [MAX_BOXES];
  logic             keeps [MAX_BOXES];
  logic signed [14:0] dw, dh;
  logic signed [29:0] area_full;

  assign pready = 1'b1;
  assign prdata = {16'h0000, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= cabs_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite && (paddr == cabs_pkg::ADDR_LIMIT)) begin
      limit_q <= pwdata[15:0];
    end
  end

  always_comb begin
    dw = $signed({1'b0, box_i.box_right}) - $signed({1'b0, box_i.box_left});
    dh = $signed({1'b0, box_i.box_bottom}) - $signed({1'b0, box_i.box_top});
    area_full = dw * dh;
    new_box.left   = box_i.box_left;
    new_box.top    = box_i.box_top;
    new_box.right  = box_i.box_right;
    new_box.bottom = box_i.box_bottom;
    new_box.score  = box_i.score;
    new_box.cls    = box_i.class_label;
    new_box.area   = area_full[28:0];
    new_box.sup    = 1'b0;
  end

  assign box_i.ready = (state_q == cabs_pkg::ST_LOAD);
  assign box_acc     = box_i.valid && box_i.ready;
  assign head        = boxes[0];
  assign out_free    = !out_v_q || kept_o.ready;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    cabs_pkg::cell_ctrl_t ctrl;
    logic                 pk;
    cabs_pkg::box_t       pb, nb;
    always_comb begin
      ctrl.load      = ld;
      ctrl.pop       = pop;
      ctrl.in_range  = (KW'(i) < k_q);
      ctrl.push_here = push_v && (pop ? (KW'(i) == k_q - KW'(1)) : (KW'(i) == k_q));
    end
    if (i == 0) begin : g_first
      assign pk = 1'b1;
      assign pb = new_box;
    end else begin : g_mid
      assign pk = keeps[i-1];
      assign pb = boxes[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_end
      assign nb = push_box;
    end else begin : g_inner
      assign nb = boxes[i+1];
    end
    cabs_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .prev_keep_i (pk),
      .prev_box_i  (pb),
      .next_box_i  (nb),
      .new_box_i   (new_box),
      .push_box_i  (push_box),
      .keep_o      (keeps[i]),
      .box_o       (boxes[i])
    );
  end

  cabs_ovl u_ovl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit_q),
    .ref_i        (ref_q),
    .x_i          (head),
    .x_valid_i    (pop && (state_q == cabs_pkg::ST_ROT)),
    .push_valid_o (push_v),
    .push_box_o   (push_box)
  );

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    pend_v_d = pend_v_q;
    ld       = 1'b0;
    pop      = 1'b0;
    grab     = 1'b0;
    out_ld   = 1'b0;
    out_fin  = 1'b0;
    case (state_q)
      cabs_pkg::ST_LOAD: begin
        if (box_acc) begin
          if (k_q == KW'(MAX_BOXES)) begin
            ovf_d = 1'b1;
          end else begin
            ld = 1'b1;
          end
          if (box_i.last_item) begin
            state_d = cabs_pkg::ST_POP;
          end
        end
      end
      cabs_pkg::ST_POP: begin
        if (k_q == '0) begin
          state_d = cabs_pkg::ST_FLUSH;
        end else if (head.sup) begin
          pop = 1'b1;
        end else if (!pend_v_q || out_free) begin
          pop      = 1'b1;
          grab     = 1'b1;
          out_ld   = pend_v_q;
          pend_v_d = 1'b1;
          rem_d    = k_q - KW'(1);
          if (k_q != KW'(1)) begin
            state_d = cabs_pkg::ST_ROT;
          end
        end
      end
      cabs_pkg::ST_ROT: begin
        pop = (rem_q != '0);
        if (pop) begin
          rem_d = rem_q - KW'(1);
        end
        if ((rem_q == '0) && !push_v) begin
          state_d = cabs_pkg::ST_POP;
        end
      end
      cabs_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_fin  = 1'b1;
          pend_v_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = cabs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = cabs_pkg::ST_LOAD;
      end
    endcase
    k_d = k_q + KW'(ld) - KW'(pop) + KW'(push_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cabs_pkg::ST_LOAD;
      k_q      <= '0;
      rem_q    <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      rem_q    <= rem_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      if (out_ld) begin
        out_v_q <= 1'b1;
      end else if (kept_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grab) begin
      pend_q <= head;
      ref_q  <= head;
    end
    if (out_ld) begin
      out_q     <= pend_q;
      out_fin_q <= out_fin;
      out_ovf_q <= ovf_q;
    end
  end

  assign kept_o.valid        = out_v_q;
  assign kept_o.kept_left    = out_q.left;
  assign kept_o.kept_top     = out_q.top;
  assign kept_o.kept_right   = out_q.right;
  assign kept_o.kept_bottom  = out_q.bottom;
  assign kept_o.kept_score   = out_q.score;
  assign kept_o.kept_class   = out_q.cls;
  assign kept_o.final_result = out_fin_q;
  assign kept_o.overflowed   = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= KW'(MAX_BOXES))
    else $error("box count exceeds capacity");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cabs_pkg::ST_LOAD) |-> !push_v)
    else $error("overlap unit busy while loading");

  a_rot_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == cabs_pkg::ST_ROT) && (rem_q == '0) && !push_v) |=>
      (state_q == cabs_pkg::ST_POP))
    else $error("rotation did not return to selection");

  a_flush_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cabs_pkg::ST_FLUSH) |-> pend_v_q)
    else $error("set closed without a kept box");

endmodule
`default_nettype wire
